/* sv/apcm_pkg.sv */
// Package for the arm proximity crossing monitor: widths, reset values, payload
// structs, state encodings and the distance saturation helper.
// Depends on nothing; every module of the block imports it.
package apcm_pkg;

  localparam int COORD_BITS   = 20;
  localparam int COUNT_BITS   = 32;
  localparam int DIST_BITS    = 42;
  localparam int TOTAL_BITS   = 32;
  localparam int CFG_IDX_BITS = 1;

  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int SQ_BITS      = 2 * DIFF_BITS;
  localparam int HALF_BITS    = DIFF_BITS;
  localparam int MUL_BITS     = DIFF_BITS + 1;
  localparam int PROD_BITS    = 2 * MUL_BITS;
  localparam int NUM_BITS     = 2 * SQ_BITS;
  localparam int ACC_BITS     = NUM_BITS + 1;
  localparam int DOT_BITS     = SQ_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SQ_BITS);
  localparam int SAT_BITS     = (SQ_BITS > DIST_BITS) ? SQ_BITS : DIST_BITS;

  localparam logic [DIST_BITS-1:0]  DIST_MAX      = {DIST_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]  COLL_THR_RST  = DIST_BITS'(32768);
  localparam logic [DIST_BITS-1:0]  WARN_THR_RST  = DIST_BITS'(65536);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COLLISION_THR,
    REG_WARNING_THR
  } cfg_reg_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_EVAL
  } top_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MAC,
    E_SEL,
    E_DIV,
    E_SUB
  } eng_e;

  typedef enum logic [2:0] {
    G_DOT,
    G_LA,
    G_LC,
    G_LE,
    G_SQ
  } grp_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] obstacle_x;
    logic signed [COORD_BITS-1:0] obstacle_y;
    logic signed [COORD_BITS-1:0] obstacle_z;
    logic                         moving;
    logic                         frame_end;
  } apcm_in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]  min_distance_sq;
    logic                  collision_event;
    logic                  warning_event;
    logic [TOTAL_BITS-1:0] collision_total;
    logic [TOTAL_BITS-1:0] warning_total;
  } apcm_out_t;

  typedef struct packed {
    logic                 done;
    logic [DIST_BITS-1:0] dist_sq;
  } apcm_res_t;

  function automatic logic [DIST_BITS-1:0] sat_dist(input logic [SQ_BITS-1:0] v);
    logic [SAT_BITS-1:0] ext;
    ext = SAT_BITS'(v);
    if (ext > SAT_BITS'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_BITS'(ext);
  endfunction

endpackage

/* sv/arm_proximity_crossing_monitor.sv */
// Top level of the arm proximity crossing monitor: handshakes, threshold
// registers, frame minimum, crossing counters and the output register.
// Depends on apcm_pkg and apcm_dist.

// Each transfer on the input is one arm segment with an obstacle point; the block
// keeps the minimum squared distance over the frame and, on the segment marked
// frame_end, emits one result with that minimum, the crossing flags and the
// saturating totals. ready stays low while a segment is worked on. Every segment
// takes 15 steps through the shared multiply-accumulate unit; when it has nonzero
// length and its projection falls on it, 42 steps of the one-bit-per-cycle
// restoring divider follow. A frame_end segment then waits in the evaluation
// state until the previous result has been taken from the output register.
module arm_proximity_crossing_monitor import apcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  apcm_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output apcm_out_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [DIST_BITS-1:0]    cfg_wdata_i
);

  top_e state_q, state_d;
  logic accept, eval_go, cev, wev;
  logic [DIST_BITS-1:0]  cthr_q, wthr_q, frame_min_q, prev_q;
  logic [COUNT_BITS-1:0] coll_q, coll_d, warn_q, warn_d;
  logic moving_q, frame_end_q, out_valid_q;
  apcm_out_t out_q;
  apcm_res_t res;

  apcm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .in_i    (in_data_i),
    .res_o   (res)
  );

  assign in_ready_o  = (state_q == T_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign eval_go = (state_q == T_EVAL) && (!out_valid_q || out_ready_i);
  assign cev = moving_q && (prev_q > cthr_q) && (frame_min_q < cthr_q);
  assign wev = !cev && moving_q && (prev_q > wthr_q) && (frame_min_q < wthr_q);
  assign coll_d = (cev && (coll_q != COUNT_MAX)) ? coll_q + COUNT_BITS'(1) : coll_q;
  assign warn_d = (wev && (warn_q != COUNT_MAX)) ? warn_q + COUNT_BITS'(1) : warn_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          state_d = T_BUSY;
        end
      end
      T_BUSY: begin
        if (res.done) begin
          state_d = frame_end_q ? T_EVAL : T_IDLE;
        end
      end
      T_EVAL: begin
        if (eval_go) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cthr_q      <= COLL_THR_RST;
      wthr_q      <= WARN_THR_RST;
      frame_min_q <= DIST_MAX;
      prev_q      <= '0;
      coll_q      <= '0;
      warn_q      <= '0;
      moving_q    <= 1'b0;
      frame_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COLLISION_THR: cthr_q <= cfg_wdata_i;
          REG_WARNING_THR:   wthr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        moving_q    <= in_data_i.moving;
        frame_end_q <= in_data_i.frame_end;
      end
      if ((state_q == T_BUSY) && res.done && (res.dist_sq < frame_min_q)) begin
        frame_min_q <= res.dist_sq;
      end
      if (eval_go) begin
        coll_q      <= coll_d;
        warn_q      <= warn_d;
        prev_q      <= frame_min_q;
        frame_min_q <= DIST_MAX;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      out_q.min_distance_sq <= frame_min_q;
      out_q.collision_event <= cev;
      out_q.warning_event   <= wev;
      out_q.collision_total <= TOTAL_BITS'(coll_d);
      out_q.warning_total   <= TOTAL_BITS'(warn_d);
    end
  end

  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.collision_event) |-> !out_q.warning_event)
    else $error("collision and warning flagged in the same frame");

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != T_BUSY) |-> !res.done)
    else $error("distance engine finished outside a busy segment");

  a_coll_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (coll_q >= $past(coll_q)))
    else $error("collision total decreased");

  a_result_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_go |-> frame_end_q)
    else $error("result produced without frame end");

endmodule

/* sv/apcm_dist.sv */
// Squared point-to-segment distance engine: one shared multiply-accumulate unit
// under a step sequencer, then a one-bit-per-cycle restoring divider.
// Depends on apcm_pkg.
module apcm_dist import apcm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  apcm_in_t  in_i,
  output apcm_res_t res_o
);

  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SQ_BITS - 1);

  eng_e state_q, state_d;
  grp_e grp_q, grp_d, p_grp_q, p_grp_d;
  logic [1:0] axis_q, axis_d, p_axis_q, p_axis_d;
  logic issue_q, issue_d, p_valid_q, p_valid_d;
  logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
  logic done_q, done_d;

  logic signed [DIFF_BITS-1:0] d_q [3];
  logic signed [DIFF_BITS-1:0] w_q [3];
  logic signed [DIFF_BITS-1:0] e_q [3];

  logic signed [MUL_BITS-1:0]  op_a, op_b;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d, prod_ext, term;

  logic signed [DOT_BITS-1:0] dot_q, dot_neg;
  logic [SQ_BITS-1:0]  dot_mag_q, la_q, lc_q, le_q;
  logic [NUM_BITS-1:0] num_q;
  logic [SQ_BITS-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic [SQ_BITS:0]    div_t;
  logic                div_ge;
  logic [DIST_BITS-1:0] dist_q;
  logic la_zero, on_seg;

  function automatic logic signed [DIFF_BITS-1:0] diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] ax, bx;
    ax = {a[COORD_BITS-1], a};
    bx = {b[COORD_BITS-1], b};
    return ax - bx;
  endfunction

  function automatic logic signed [MUL_BITS-1:0] sx(input logic signed [DIFF_BITS-1:0] v);
    return {v[DIFF_BITS-1], v};
  endfunction

  assign la_zero = (la_q == '0);
  assign on_seg  = (dot_q[DOT_BITS-1] || (dot_q == '0)) && (dot_mag_q <= la_q);
  assign dot_neg = -dot_q;

  assign div_t  = {rem_q, quo_q[SQ_BITS-1]};
  assign div_ge = (div_t >= {1'b0, la_q});
  assign rem_d  = div_ge ? SQ_BITS'(div_t - {1'b0, la_q}) : div_t[SQ_BITS-1:0];
  assign quo_d  = {quo_q[SQ_BITS-2:0], div_ge};

  always_comb begin
    op_a = sx(d_q[axis_q]);
    op_b = sx(d_q[axis_q]);
    unique case (grp_q)
      G_DOT: begin
        op_a = sx(w_q[axis_q]);
        op_b = sx(d_q[axis_q]);
      end
      G_LA: begin
        op_a = sx(d_q[axis_q]);
        op_b = sx(d_q[axis_q]);
      end
      G_LC: begin
        op_a = sx(w_q[axis_q]);
        op_b = sx(w_q[axis_q]);
      end
      G_LE: begin
        op_a = sx(e_q[axis_q]);
        op_b = sx(e_q[axis_q]);
      end
      G_SQ: begin
        op_a = {1'b0, dot_mag_q[SQ_BITS-1:HALF_BITS]};
        op_b = {1'b0, dot_mag_q[SQ_BITS-1:HALF_BITS]};
        if (axis_q == 2'd1) begin
          op_b = {1'b0, dot_mag_q[HALF_BITS-1:0]};
        end else if (axis_q == AXIS_LAST) begin
          op_a = {1'b0, dot_mag_q[HALF_BITS-1:0]};
          op_b = {1'b0, dot_mag_q[HALF_BITS-1:0]};
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
    term     = prod_ext;
    if (p_grp_q == G_SQ) begin
      if (p_axis_q == 2'd0) begin
        term = prod_ext <<< (2 * HALF_BITS);
      end else if (p_axis_q == 2'd1) begin
        term = prod_ext <<< (HALF_BITS + 1);
      end
    end
    acc_d = ((p_axis_q == 2'd0) ? ACC_BITS'(0) : acc_q) + term;
  end

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    axis_d    = axis_q;
    issue_d   = issue_q;
    p_valid_d = issue_q;
    p_grp_d   = grp_q;
    p_axis_d  = axis_q;
    div_cnt_d = div_cnt_q;
    done_d    = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          state_d = E_MAC;
          grp_d   = G_DOT;
          axis_d  = 2'd0;
          issue_d = 1'b1;
        end
      end
      E_MAC: begin
        if (issue_q) begin
          if (axis_q == AXIS_LAST) begin
            axis_d = 2'd0;
            unique case (grp_q)
              G_DOT:   grp_d = G_LA;
              G_LA:    grp_d = G_LC;
              G_LC:    grp_d = G_LE;
              G_LE:    grp_d = G_SQ;
              default: issue_d = 1'b0;
            endcase
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end
        if (p_valid_q && (p_grp_q == G_SQ) && (p_axis_q == AXIS_LAST)) begin
          state_d = E_SEL;
        end
      end
      E_SEL: begin
        if (la_zero || !on_seg) begin
          done_d  = 1'b1;
          state_d = E_IDLE;
        end else begin
          div_cnt_d = '0;
          state_d   = E_DIV;
        end
      end
      E_DIV: begin
        div_cnt_d = div_cnt_q + DIV_CNT_BITS'(1);
        if (div_cnt_q == DIV_LAST) begin
          state_d = E_SUB;
        end
      end
      E_SUB: begin
        done_d  = 1'b1;
        state_d = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= E_IDLE;
      grp_q     <= G_DOT;
      axis_q    <= 2'd0;
      issue_q   <= 1'b0;
      p_valid_q <= 1'b0;
      p_grp_q   <= G_DOT;
      p_axis_q  <= 2'd0;
      div_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_q     <= grp_d;
      axis_q    <= axis_d;
      issue_q   <= issue_d;
      p_valid_q <= p_valid_d;
      p_grp_q   <= p_grp_d;
      p_axis_q  <= p_axis_d;
      div_cnt_q <= div_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == E_IDLE) && start_i) begin
      d_q[0] <= diff(in_i.end_x, in_i.start_x);
      d_q[1] <= diff(in_i.end_y, in_i.start_y);
      d_q[2] <= diff(in_i.end_z, in_i.start_z);
      w_q[0] <= diff(in_i.start_x, in_i.obstacle_x);
      w_q[1] <= diff(in_i.start_y, in_i.obstacle_y);
      w_q[2] <= diff(in_i.start_z, in_i.obstacle_z);
      e_q[0] <= diff(in_i.end_x, in_i.obstacle_x);
      e_q[1] <= diff(in_i.end_y, in_i.obstacle_y);
      e_q[2] <= diff(in_i.end_z, in_i.obstacle_z);
    end
    prod_q    <= op_a * op_b;
    dot_mag_q <= dot_q[DOT_BITS-1] ? dot_neg[SQ_BITS-1:0] : dot_q[SQ_BITS-1:0];
    if (p_valid_q) begin
      acc_q <= acc_d;
      if (p_axis_q == AXIS_LAST) begin
        unique case (p_grp_q)
          G_DOT:   dot_q <= acc_d[DOT_BITS-1:0];
          G_LA:    la_q  <= acc_d[SQ_BITS-1:0];
          G_LC:    lc_q  <= acc_d[SQ_BITS-1:0];
          G_LE:    le_q  <= acc_d[SQ_BITS-1:0];
          default: num_q <= acc_d[NUM_BITS-1:0];
        endcase
      end
    end
    if (state_q == E_SEL) begin
      if (la_zero) begin
        dist_q <= sat_dist(lc_q);
      end else if (on_seg) begin
        rem_q <= num_q[NUM_BITS-1:SQ_BITS];
        quo_q <= num_q[SQ_BITS-1:0];
      end else begin
        dist_q <= sat_dist((lc_q < le_q) ? lc_q : le_q);
      end
    end
    if (state_q == E_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (state_q == E_SUB) begin
      dist_q <= sat_dist((quo_q <= lc_q) ? (lc_q - quo_q) : SQ_BITS'(0));
    end
  end

  assign res_o.done    = done_q;
  assign res_o.dist_sq = dist_q;

  a_div_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_DIV) |-> (rem_q < la_q))
    else $error("divider remainder not below divisor");

  a_done_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

  a_mac_drained_at_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_SEL) |-> (!issue_q && !p_valid_q))
    else $error("multiply-accumulate still busy at branch select");

endmodule
